FILE: rtl/core/qlm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qlm_pkg;

  // Widths fixed by the word format on the ports
  localparam int unsigned LockInW  = 5;
  localparam int unsigned LockIdxW = LockInW - 1;
  localparam int unsigned PidInW   = 8;
  localparam int unsigned StatusW  = 4;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_GRANTED   = 4'd0,
    ST_REENTRANT = 4'd1,
    ST_QUEUED    = 4'd2,
    ST_FULL      = 4'd3,
    ST_IGNORED   = 4'd4,
    ST_EMPTIED   = 4'd5,
    ST_PASSED_ON = 4'd6,
    ST_NOT_OWNER = 4'd7,
    ST_UNLOCKED  = 4'd8
  } status_e;

  // Classified request, as held between front and back
  typedef struct packed {
    op_e                 op;
    logic                ignore;
    logic [LockIdxW-1:0] lock;
    logic [PidInW-1:0]   pid;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic              wake_valid;
    logic [PidInW-1:0] wake_pid;
    logic              owner_valid;
    logic [PidInW-1:0] owner_pid;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/qlm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module qlm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/qlm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module qlm_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  qlm_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output qlm_pkg::cmd_t rdata_o,
  output logic          empty_o
);
  import qlm_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       do_push, do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/qlm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module qlm_front #(
  parameter int unsigned LOCK_COUNT = 16
) (
  input  logic                         push_i,
  input  logic                         queue_full_i,
  input  logic                         opcode_i,
  input  logic [qlm_pkg::LockInW-1:0]  lock_id_i,
  input  logic [qlm_pkg::PidInW-1:0]   requester_i,
  output logic                         push_o,
  output qlm_pkg::cmd_t                cmd_o
);
  import qlm_pkg::*;

  logic out_of_range;

  // Negative ids have the sign bit set; the rest are checked against the lock count
  assign out_of_range = (32'(lock_id_i[LockIdxW-1:0]) >= 32'(LOCK_COUNT));

  assign push_o       = push_i && !queue_full_i;
  assign cmd_o.op     = op_e'(opcode_i);
  assign cmd_o.ignore = lock_id_i[LockInW-1] || out_of_range;
  assign cmd_o.lock   = lock_id_i[LockIdxW-1:0];
  assign cmd_o.pid    = requester_i;

endmodule

`default_nettype wire

FILE: rtl/core/qlm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module qlm_back #(
  parameter int unsigned LOCK_COUNT  = 16,
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned PID_BITS    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  qlm_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          res_valid_o,
  output qlm_pkg::res_t res_o,
  input  logic          res_pop_i
);
  import qlm_pkg::*;

  localparam int unsigned LW    = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int unsigned HW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DEPTH = LOCK_COUNT * QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = (PID_BITS < PidInW) ? PID_BITS : PidInW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_NEXT = 3'b100
  } state_e;

  state_e         state_q, state_d;
  cmd_t           cmd_q, cmd_d;
  logic [HW-1:0]  head_q  [LOCK_COUNT];
  logic [CW-1:0]  count_q [LOCK_COUNT];
  res_t           res_q, res_d;
  logic           res_valid_q;
  logic           res_load;

  logic           upd;
  logic [HW-1:0]  upd_head;
  logic [CW-1:0]  upd_count;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [SW-1:0]  ram_wdata, ram_rdata;

  logic [LW-1:0]  lk_new, lk;
  logic [HW-1:0]  cur_head, next_head, tail;
  logic [CW-1:0]  cur_count;
  logic [SW-1:0]  pid;
  logic           match, out_free;
  int unsigned    tail_sum;

  function automatic logic [AW-1:0] slot_addr(logic [LW-1:0] lock, logic [HW-1:0] ring);
    return AW'(32'(lock) * QUEUE_DEPTH + 32'(ring));
  endfunction

  qlm_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_waiters (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign lk_new    = LW'(cmd_i.lock);
  assign lk        = LW'(cmd_q.lock);
  assign cur_head  = head_q[lk];
  assign cur_count = count_q[lk];
  assign pid       = cmd_q.pid[SW-1:0];
  assign match     = (ram_rdata == pid);
  assign next_head = (cur_head == HW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + HW'(1);
  assign tail_sum  = 32'(cur_head) + 32'(cur_count);
  assign tail      = (tail_sum >= QUEUE_DEPTH) ? HW'(tail_sum - QUEUE_DEPTH) : HW'(tail_sum);
  assign out_free  = !res_valid_q || res_pop_i;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    cmd_pop_o = 1'b0;
    res_d     = '0;
    res_load  = 1'b0;
    upd       = 1'b0;
    upd_head  = cur_head;
    upd_count = cur_count;
    ram_we    = 1'b0;
    ram_waddr = slot_addr(lk, '0);
    ram_wdata = pid;
    ram_re    = 1'b0;
    ram_raddr = slot_addr(lk_new, head_q[lk_new]);

    unique case (state_q)
      S_IDLE: begin
        // Start only with the result slot free, so the finished word always lands
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          if (cmd_i.ignore) begin
            res_d.status = ST_IGNORED;
            res_load     = 1'b1;
          end else begin
            ram_re  = 1'b1;
            state_d = S_EVAL;
          end
        end
      end

      S_EVAL: begin
        state_d = S_IDLE;
        if (cmd_q.op == OP_ACQUIRE) begin
          res_load          = 1'b1;
          res_d.owner_valid = 1'b1;
          res_d.owner_pid   = PidInW'(ram_rdata);
          if (cur_count == '0) begin
            ram_we          = 1'b1;
            upd             = 1'b1;
            upd_head        = '0;
            upd_count       = CW'(1);
            res_d.status    = ST_GRANTED;
            res_d.owner_pid = PidInW'(pid);
          end else if (match) begin
            res_d.status = ST_REENTRANT;
          end else if (cur_count == CW'(QUEUE_DEPTH)) begin
            res_d.status = ST_FULL;
          end else begin
            ram_we       = 1'b1;
            ram_waddr    = slot_addr(lk, tail);
            upd          = 1'b1;
            upd_count    = cur_count + CW'(1);
            res_d.status = ST_QUEUED;
          end
        end else begin
          if (cur_count == '0) begin
            res_load     = 1'b1;
            res_d.status = ST_UNLOCKED;
          end else if (cur_count == CW'(1)) begin
            res_load     = 1'b1;
            upd          = 1'b1;
            upd_head     = '0;
            upd_count    = '0;
            res_d.status = ST_EMPTIED;
          end else if (match) begin
            // Pop the owner, then fetch the new head to wake it
            upd       = 1'b1;
            upd_head  = next_head;
            upd_count = cur_count - CW'(1);
            ram_re    = 1'b1;
            ram_raddr = slot_addr(lk, next_head);
            state_d   = S_NEXT;
          end else begin
            res_load          = 1'b1;
            res_d.status      = ST_NOT_OWNER;
            res_d.wake_valid  = 1'b1;
            res_d.wake_pid    = PidInW'(ram_rdata);
            res_d.owner_valid = 1'b1;
            res_d.owner_pid   = PidInW'(ram_rdata);
          end
        end
      end

      S_NEXT: begin
        state_d           = S_IDLE;
        res_load          = 1'b1;
        res_d.status      = ST_PASSED_ON;
        res_d.wake_valid  = 1'b1;
        res_d.wake_pid    = PidInW'(ram_rdata);
        res_d.owner_valid = 1'b1;
        res_d.owner_pid   = PidInW'(ram_rdata);
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (res_load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      for (int i = 0; i < LOCK_COUNT; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
      if (upd) begin
        head_q[lk]  <= upd_head;
        count_q[lk] <= upd_count;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

FILE: rtl/core/queued_lock_manager_top.sv
// Queued lock manager: LOCK_COUNT locks, each with a first-in-first-out queue of
// requester ids whose head owns the lock.
// Request side: a word is taken at a rising edge with push high and full low.
//   Words land in a two-entry queue, so two requests may wait while the back end
//   is busy or the result is not yet taken.
// Result side: while empty is low the oldest result word sits on the result
//   ports; pop takes it. One result word comes back for every request word.
// Timing: the back end works one request at a time. An ignored lock id is
//   answered from the idle state, an acquire or most releases need a waiter
//   memory read, then the update, and a release that passes the lock on needs a
//   second read to fetch the new owner.
// Stall: while a result word waits, the back end holds the next request in the
//   queue; once the queue is full, full rises until pop drains a word.
// Reset: rst_ni clears every lock to free and both queues to empty; the waiter
//   memory needs no clearing as only entries inside a queue are ever used.
`timescale 1ns / 1ps
`default_nettype none

module queued_lock_manager_top #(
  parameter int unsigned LOCK_COUNT  = 16,
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned PID_BITS    = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request queue side
  input  logic                                push,
  output logic                                full,
  input  logic                                opcode_i,
  input  logic [qlm_pkg::LockInW-1:0]         lock_id_i,
  input  logic [qlm_pkg::PidInW-1:0]          requester_i,
  // result queue side
  output logic                                empty,
  input  logic                                pop,
  output logic [qlm_pkg::StatusW-1:0]         status_o,
  output logic                                wake_valid_o,
  output logic [qlm_pkg::PidInW-1:0]          wake_pid_o,
  output logic                                owner_valid_o,
  output logic [qlm_pkg::PidInW-1:0]          owner_pid_o
);
  import qlm_pkg::*;

  cmd_t front_cmd, queued_cmd;
  logic front_push, cmd_full, cmd_empty, cmd_pop;
  res_t res;
  logic res_valid;

  // Classify the request word and gate the push against the command queue
  qlm_front #(
    .LOCK_COUNT (LOCK_COUNT)
  ) u_front (
    .push_i       (push),
    .queue_full_i (cmd_full),
    .opcode_i     (opcode_i),
    .lock_id_i    (lock_id_i),
    .requester_i  (requester_i),
    .push_o       (front_push),
    .cmd_o        (front_cmd)
  );

  // Hold classified requests so the front keeps taking words while the back works
  qlm_fifo u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .wdata_i (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (queued_cmd),
    .empty_o (cmd_empty)
  );

  // Read-modify-write of the per-lock queue and the result register
  qlm_back #(
    .LOCK_COUNT  (LOCK_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PID_BITS    (PID_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (queued_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  assign full          = cmd_full;
  assign empty         = !res_valid;
  assign status_o      = res.status;
  assign wake_valid_o  = res.wake_valid;
  assign wake_pid_o    = res.wake_pid;
  assign owner_valid_o = res.owner_valid;
  assign owner_pid_o   = res.owner_pid;

endmodule

`default_nettype wire
